FILE: rtl/bads_pkg.sv
// box average downscaler: shared types, constants and the block-mean function
// no dependencies; used by box_average_downscaler_unit and the testbench
`default_nettype none

package bads_pkg;

    localparam int CH_W      = 8;   // pixel channel width
    localparam int SUM_W     = 12;  // channel sum width, wraps modulo 4096
    localparam int CFG_W     = 9;   // widest configuration register
    localparam int INDEX_W   = 1;   // configuration register index width
    localparam int SCALE_W   = 3;   // scale factor register width
    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 8;

    // configuration register indexes
    localparam logic [INDEX_W-1:0] CFG_SCALE_FACTOR = 1'b0;
    localparam logic [INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b1;

    // block edge lengths
    localparam logic [SCALE_W-1:0] F_HALF    = 3'd2;
    localparam logic [SCALE_W-1:0] F_THIRD   = 3'd3;
    localparam logic [SCALE_W-1:0] F_QUARTER = 3'd4;

    // reset values of the configuration registers
    localparam logic [SCALE_W-1:0] SCALE_RESET = 3'd2;
    localparam logic [CFG_W-1:0]   WIDTH_RESET = 9'd256;

    // divide by 9 as multiply by reciprocal, exact for every 12-bit channel sum
    localparam int                 DIV9_SHIFT = 19;
    localparam int                 DIV9_PW    = 28;
    localparam logic [15:0]        DIV9_MUL   = 16'd58255;

    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } sums_t;

    // truncated mean of one channel sum over an f-by-f block, masked to 8 bits
    function automatic logic [CH_W-1:0] block_mean(input logic [SUM_W-1:0] s,
                                                   input logic [SCALE_W-1:0] f);
        logic [DIV9_PW-1:0] p;
        logic [CH_W-1:0]    m;
        p = DIV9_PW'(s) * DIV9_PW'(DIV9_MUL);
        case (f)
            F_THIRD:   m = p[DIV9_SHIFT +: CH_W];
            F_QUARTER: m = s[SUM_W-1:4];
            default:   m = s[CH_W+1:2];
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/box_average_downscaler_unit.sv
// box average downscaler: top level, position counters, line accumulator, result register
// depends on bads_pkg
`default_nettype none

// a completing beat is registered in the accumulate stage, then in the result register
// throughput: one pixel beat per cycle, unless a completing pixel waits on a full result
//   register; set by the line accumulator read-modify-write with a one-entry bypass
// reset: synchronous active-low aresetn clears counters, pipeline valids and config
//   registers; the accumulator memory is not cleared (every entry is written at the first
//   pixel of its block before it is read)
module box_average_downscaler_unit #(
    parameter int MAX_WIDTH = 256
) (
    input  wire                                aclk,
    input  wire                                aresetn,

    // configuration write port
    input  wire                                cfg_wr_en,
    input  wire  [bads_pkg::INDEX_W-1:0]       cfg_index,
    input  wire  [bads_pkg::CFG_W-1:0]         cfg_wdata,

    // pixel input
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [bads_pkg::CH_W-1:0]          s_pixel_red,
    input  wire  [bads_pkg::CH_W-1:0]          s_pixel_green,
    input  wire  [bads_pkg::CH_W-1:0]          s_pixel_blue,
    input  wire                                s_frame_start,

    // shrunk pixel output
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [bads_pkg::CH_W-1:0]          m_out_red,
    output logic [bads_pkg::CH_W-1:0]          m_out_green,
    output logic [bads_pkg::CH_W-1:0]          m_out_blue,
    output logic [bads_pkg::OUT_COL_W-1:0]     m_out_col,
    output logic [bads_pkg::OUT_ROW_W-1:0]     m_out_row
);

    // derived sizes
    localparam int SUM_DEPTH = MAX_WIDTH / 2;               // accumulator entries
    localparam int AW        = $clog2(SUM_DEPTH);           // accumulator address width
    localparam int IC_W      = $clog2(MAX_WIDTH);           // column counter width
    localparam int W_W       = IC_W + 1;                    // clamped width, holds MAX_WIDTH
    localparam int CMP_W     = (W_W > bads_pkg::CFG_W) ? W_W : bads_pkg::CFG_W;
    localparam int PW        = IC_W + 3;                    // (column + 1) * factor

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [bads_pkg::SCALE_W-1:0] scale_reg;
    logic [bads_pkg::CFG_W-1:0]   width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= bads_pkg::SCALE_RESET;
            width_reg <= bads_pkg::WIDTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bads_pkg::CFG_SCALE_FACTOR: scale_reg <= cfg_wdata[bads_pkg::SCALE_W-1:0];
                bads_pkg::CFG_IMAGE_WIDTH:  width_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp factor to 2..4 and width to 1..MAX_WIDTH
    logic [bads_pkg::SCALE_W-1:0] f;
    logic [W_W-1:0]               w;
    logic [CMP_W-1:0]             width_wide;

    always_comb begin
        if (scale_reg < bads_pkg::F_HALF) begin
            f = bads_pkg::F_HALF;
        end else if (scale_reg > bads_pkg::F_QUARTER) begin
            f = bads_pkg::F_QUARTER;
        end else begin
            f = scale_reg;
        end

        width_wide = CMP_W'(width_reg);
        if (width_reg == '0) begin
            w = W_W'(1);
        end else if (width_wide > CMP_W'(MAX_WIDTH)) begin
            w = W_W'(MAX_WIDTH);
        end else begin
            w = W_W'(width_wide);
        end
    end

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------
    logic s_accept;
    logic s1_valid_reg, s1_valid_next;
    logic s1_advance;
    logic s1_last_reg;
    logic out_valid_reg;

    // the stage holding a completing pixel waits only when the result register is full
    assign s1_advance = s1_valid_reg && !(s1_last_reg && out_valid_reg && !m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // position counters, taken at accept
    // ------------------------------------------------------------------
    logic [IC_W-1:0]               ic_reg, ic_next, ic_cur;
    logic [1:0]                    cib_reg, cib_next, cib_cur;
    logic [1:0]                    rib_reg, rib_next, rib_cur;
    logic [IC_W-1:0]               oc_reg, oc_next, oc_cur;
    logic [bads_pkg::OUT_ROW_W-1:0] or_reg, or_next, or_cur;

    logic [W_W-1:0]                ic_inc;
    logic [2:0]                    cib_inc, rib_inc;
    logic [IC_W:0]                 oc_inc;
    logic [PW-1:0]                 block_end;
    logic                          in_range, first, last;

    always_comb begin
        // frame start clears positions before this pixel is placed
        if (s_frame_start) begin
            ic_cur  = '0;
            cib_cur = '0;
            rib_cur = '0;
            oc_cur  = '0;
            or_cur  = '0;
        end else begin
            ic_cur  = ic_reg;
            cib_cur = cib_reg;
            rib_cur = rib_reg;
            oc_cur  = oc_reg;
            or_cur  = or_reg;
        end

        cib_inc   = {1'b0, cib_cur} + 3'd1;
        rib_inc   = {1'b0, rib_cur} + 3'd1;
        ic_inc    = {1'b0, ic_cur} + W_W'(1);
        oc_inc    = {1'b0, oc_cur} + (IC_W+1)'(1);

        // block fits in the row when (column + 1) * f <= width
        block_end = PW'(oc_inc) * PW'(f);
        in_range  = (block_end <= PW'(w)) && (oc_inc <= (IC_W+1)'(SUM_DEPTH));
        first     = (rib_cur == 2'd0) && (cib_cur == 2'd0);
        last      = in_range && (rib_inc >= f) && (cib_inc >= f);

        // advance along the row
        if (cib_inc >= f) begin
            cib_next = '0;
            oc_next  = oc_inc[IC_W-1:0];
        end else begin
            cib_next = cib_inc[1:0];
            oc_next  = oc_cur;
        end
        rib_next = rib_cur;
        or_next  = or_cur;

        // end of input row
        if (ic_inc >= w) begin
            ic_next  = '0;
            cib_next = '0;
            oc_next  = '0;
            if (rib_inc >= f) begin
                rib_next = '0;
                or_next  = or_cur + bads_pkg::OUT_ROW_W'(1);
            end else begin
                rib_next = rib_inc[1:0];
            end
        end else begin
            ic_next = ic_inc[IC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ic_reg  <= '0;
            cib_reg <= '0;
            rib_reg <= '0;
            oc_reg  <= '0;
            or_reg  <= '0;
        end else if (s_accept) begin
            ic_reg  <= ic_next;
            cib_reg <= cib_next;
            rib_reg <= rib_next;
            oc_reg  <= oc_next;
            or_reg  <= or_next;
        end
    end

    // ------------------------------------------------------------------
    // accumulate stage
    // ------------------------------------------------------------------
    logic                           s1_first_reg, s1_inrange_reg, s1_fwd_reg;
    logic [AW-1:0]                  s1_addr_reg;
    logic [bads_pkg::CH_W-1:0]      s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [bads_pkg::OUT_COL_W-1:0] s1_col_reg;
    logic [bads_pkg::OUT_ROW_W-1:0] s1_row_reg;
    logic [AW-1:0]                  rd_addr;
    logic                           fwd_hit;

    assign rd_addr = AW'(oc_cur);
    // previous pixel writes the entry this pixel reads in the same cycle: bypass it
    assign fwd_hit = s1_valid_reg && s1_inrange_reg && (s1_addr_reg == rd_addr);

    always_comb begin
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_first_reg   <= first;
            s1_last_reg    <= last;
            s1_inrange_reg <= in_range;
            s1_fwd_reg     <= fwd_hit;
            s1_addr_reg    <= rd_addr;
            s1_red_reg     <= s_pixel_red;
            s1_green_reg   <= s_pixel_green;
            s1_blue_reg    <= s_pixel_blue;
            s1_col_reg     <= bads_pkg::OUT_COL_W'(oc_cur);
            s1_row_reg     <= or_cur;
        end
    end

    // line accumulator: one set of channel sums per output column
    bads_pkg::sums_t sum_mem [SUM_DEPTH];
    bads_pkg::sums_t rdata_reg;
    bads_pkg::sums_t last_wr_reg;
    bads_pkg::sums_t base, sum_new;
    logic            wr_en;

    assign wr_en = s1_advance && s1_inrange_reg;

    always_comb begin
        base = s1_fwd_reg ? last_wr_reg : rdata_reg;
        if (s1_first_reg) begin
            sum_new.red   = bads_pkg::SUM_W'(s1_red_reg);
            sum_new.green = bads_pkg::SUM_W'(s1_green_reg);
            sum_new.blue  = bads_pkg::SUM_W'(s1_blue_reg);
        end else begin
            sum_new.red   = base.red   + bads_pkg::SUM_W'(s1_red_reg);
            sum_new.green = base.green + bads_pkg::SUM_W'(s1_green_reg);
            sum_new.blue  = base.blue  + bads_pkg::SUM_W'(s1_blue_reg);
        end
    end

    // read at accept returns the old word when the same entry is written that cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sum_mem[s1_addr_reg] <= sum_new;
        end
        if (s_accept) begin
            rdata_reg <= sum_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            last_wr_reg <= sum_new;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic out_load;

    assign out_load = s1_advance && s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_out_red   <= bads_pkg::block_mean(sum_new.red, f);
            m_out_green <= bads_pkg::block_mean(sum_new.green, f);
            m_out_blue  <= bads_pkg::block_mean(sum_new.blue, f);
            m_out_col   <= s1_col_reg;
            m_out_row   <= s1_row_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// testbench for box_average_downscaler_unit: pixel beats in, shrunk pixel beats out
// holds its own line accumulator mirror and checks every block mean in order
// depends on bads_pkg and box_average_downscaler_unit
`default_nettype none

module tb;
    import bads_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int MAX_W         = 256;
    localparam int LINE_DEPTH    = MAX_W / 2;
    localparam int ITEM_TARGET   = 1850;
    localparam int CALM_FROM     = ITEM_TARGET - 150;  // last stretch runs flat out
    localparam int SETTLE_CYCLES = 8;                  // well past the pipeline latency
    localparam int DRAIN_LIMIT   = 4000;
    localparam int RUN_LIMIT     = 600000;             // cycles

    // one shrunk pixel as it leaves the block
    typedef struct {
        logic [CH_W-1:0]      red;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      blue;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
    } shrunk_px_t;

    // mirror of the downscaler: position counters, line sums and the queue of
    // block means still to come out
    class box_mean_scoreboard;
        logic [SCALE_W-1:0] scale_reg;
        logic [CFG_W-1:0]   width_reg;
        sums_t              line_sums [LINE_DEPTH];
        int unsigned        in_col, col_in_blk, row_in_blk, blk_col, blk_row;
        shrunk_px_t         awaited [$];
        int                 errors;

        function new();
            scale_reg  = SCALE_RESET;
            width_reg  = WIDTH_RESET;
            foreach (line_sums[i]) line_sums[i] = '0;
            in_col     = 0;
            col_in_blk = 0;
            row_in_blk = 0;
            blk_col    = 0;
            blk_row    = 0;
            errors     = 0;
        endfunction

        task report(string msg);
            if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void note_config(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] word);
            if (idx == CFG_SCALE_FACTOR) scale_reg = word[SCALE_W-1:0];
            else if (idx == CFG_IMAGE_WIDTH) width_reg = word;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // fold one accepted pixel into the line sums, queue a mean when a block closes
        function void take_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                 input logic [CH_W-1:0] b, input logic fs);
            int unsigned f, w;
            sums_t       acc;
            shrunk_px_t  px;
            f = scale_reg;
            if (f < 2) f = 2;
            else if (f > 4) f = 4;
            w = width_reg;
            if (w < 1) w = 1;
            else if (w > MAX_W) w = MAX_W;
            if (fs) begin
                in_col     = 0;
                col_in_blk = 0;
                row_in_blk = 0;
                blk_col    = 0;
                blk_row    = 0;
            end
            if (blk_col < w / f && blk_col < LINE_DEPTH) begin
                acc = line_sums[blk_col];
                if (row_in_blk == 0 && col_in_blk == 0) acc = '0;
                acc.red   = acc.red + SUM_W'(r);
                acc.green = acc.green + SUM_W'(g);
                acc.blue  = acc.blue + SUM_W'(b);
                line_sums[blk_col] = acc;
                if (row_in_blk + 1 >= f && col_in_blk + 1 >= f) begin
                    px.red   = CH_W'(acc.red / (f * f));
                    px.green = CH_W'(acc.green / (f * f));
                    px.blue  = CH_W'(acc.blue / (f * f));
                    px.col   = OUT_COL_W'(blk_col);
                    px.row   = OUT_ROW_W'(blk_row);
                    awaited.push_back(px);
                end
            end
            in_col++;
            col_in_blk++;
            if (col_in_blk >= f) begin
                col_in_blk = 0;
                blk_col++;
            end
            if (in_col >= w) begin
                in_col     = 0;
                col_in_blk = 0;
                blk_col    = 0;
                row_in_blk++;
                if (row_in_blk >= f) begin
                    row_in_blk = 0;
                    blk_row    = (blk_row + 1) % 256;
                end
            end
        endfunction

        task check_block(shrunk_px_t got);
            shrunk_px_t want;
            if (awaited.size() == 0) begin
                report($sformatf("shrunk pixel col %0d row %0d with nothing awaited",
                                 got.col, got.row));
                return;
            end
            want = awaited.pop_front();
            if (got.red !== want.red)
                report($sformatf("red at col %0d row %0d: got %0d, want %0d",
                                 want.col, want.row, got.red, want.red));
            if (got.green !== want.green)
                report($sformatf("green at col %0d row %0d: got %0d, want %0d",
                                 want.col, want.row, got.green, want.green));
            if (got.blue !== want.blue)
                report($sformatf("blue at col %0d row %0d: got %0d, want %0d",
                                 want.col, want.row, got.blue, want.blue));
            if (got.col !== want.col)
                report($sformatf("column: got %0d, want %0d", got.col, want.col));
            if (got.row !== want.row)
                report($sformatf("row: got %0d, want %0d", got.row, want.row));
        endtask

        // anything still awaited after a long drain is lost
        task give_up();
            if (awaited.size() != 0) begin
                report($sformatf("%0d shrunk pixel(s) never came out", awaited.size()));
                awaited.delete();
            end
        endtask
    endclass

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // everything the block sees starts at a known value
    logic                 cfg_wr_en     = 1'b0;
    logic [INDEX_W-1:0]   cfg_index     = CFG_SCALE_FACTOR;
    logic [CFG_W-1:0]     cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [CH_W-1:0]      s_pixel_red   = '0;
    logic [CH_W-1:0]      s_pixel_green = '0;
    logic [CH_W-1:0]      s_pixel_blue  = '0;
    logic                 s_frame_start = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [CH_W-1:0]      m_out_red;
    logic [CH_W-1:0]      m_out_green;
    logic [CH_W-1:0]      m_out_blue;
    logic [OUT_COL_W-1:0] m_out_col;
    logic [OUT_ROW_W-1:0] m_out_row;

    box_average_downscaler_unit #(
        .MAX_WIDTH (MAX_W)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_red   (s_pixel_red),
        .s_pixel_green (s_pixel_green),
        .s_pixel_blue  (s_pixel_blue),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_out_col     (m_out_col),
        .m_out_row     (m_out_row)
    );

    box_mean_scoreboard sb;

    int pixels_sent = 0;
    bit calm        = 1'b0;  // no idling on either side once set
    int idle_odds   = 6;     // sender gap starts one beat in idle_odds, 0 for none
    int stall_odds  = 6;     // receiver stall starts one cycle in stall_odds, 0 for none
    int stall_left  = 0;

    // receiver: ready drops in bursts of random length, changed at the falling edge
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left = $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // every result beat taken at the rising edge is checked against the oldest mean
    always @(posedge aclk) begin : catch_result
        shrunk_px_t seen;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            seen.red   = m_out_red;
            seen.green = m_out_green;
            seen.blue  = m_out_blue;
            seen.col   = m_out_col;
            seen.row   = m_out_row;
            sb.check_block(seen);
        end
    end

    // channel value with the extremes well represented
    function automatic logic [CH_W-1:0] pick_chan();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one pixel beat, entered and left at the falling edge; an idle burst may go first
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b, input logic fs);
        if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_red   <= r;
        s_pixel_green <= g;
        s_pixel_blue  <= b;
        s_frame_start <= fs;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        sb.take_pixel(r, g, b, fs);
        pixels_sent++;
        if (pixels_sent >= CALM_FROM) calm = 1'b1;
        @(negedge aclk);
    endtask

    // hold the sender until every awaited mean is out, then let the pipeline empty
    task automatic drain();
        int c;
        s_valid <= 1'b0;
        c = 0;
        while (sb.pending() != 0 && c < DRAIN_LIMIT) begin
            @(negedge aclk);
            c++;
        end
        sb.give_up();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // register writes, only ever made with the block idle; the factor word carries
    // random upper bits that the block has to ignore
    task automatic set_config(input bit do_scale, input logic [SCALE_W-1:0] sc,
                              input bit do_width, input logic [CFG_W-1:0] wd);
        logic [CFG_W-1:0] word;
        if (do_scale) begin
            word = {(CFG_W - SCALE_W)'($urandom), sc};
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_SCALE_FACTOR;
            cfg_wdata <= word;
            @(posedge aclk);
            sb.note_config(CFG_SCALE_FACTOR, word);
            @(negedge aclk);
        end
        if (do_width) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IMAGE_WIDTH;
            cfg_wdata <= wd;
            @(posedge aclk);
            sb.note_config(CFG_IMAGE_WIDTH, wd);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // one random phase: new settings, then mostly a well-formed frame with random
    // pixels, cut off somewhere in a block row; now and then a stray frame start,
    // a very wide truncated frame, or a carry-on in the old frame under new settings
    task automatic run_phase(input int phase_no);
        logic [SCALE_W-1:0] sc;
        logic [CFG_W-1:0]   wd;
        int                 f_eff, w_eff, n_px;
        bit                 wide, resume;
        logic               fs;
        wide   = ($urandom_range(0, 5) == 0);
        resume = ($urandom_range(0, 4) == 0);
        if (phase_no == 0) sc = 3'd7;                       // above range, taken as quarters
        else if (phase_no == 1) sc = 3'd0;                  // below range, taken as halves
        else if ($urandom_range(0, 3) == 0) sc = SCALE_W'($urandom_range(0, 7));
        else sc = SCALE_W'($urandom_range(2, 4));
        if (wide)
            wd = ($urandom_range(0, 1) == 1) ? CFG_W'(MAX_W) : CFG_W'($urandom_range(257, 511));
        else if (phase_no == 2 || $urandom_range(0, 15) == 0)
            wd = '0;                                        // zero width, taken as one
        else
            wd = CFG_W'($urandom_range(1, 24));
        f_eff = (sc < 2) ? 2 : (sc > 4) ? 4 : int'(sc);
        w_eff = (wd == 0) ? 1 : (wd > MAX_W) ? MAX_W : int'(wd);
        if (wide) n_px = $urandom_range(20, 100);
        else n_px = f_eff * w_eff * $urandom_range(1, 3) + $urandom_range(0, f_eff * w_eff - 1);
        drain();
        set_config(1'b1, sc, 1'b1, wd);
        idle_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
        stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
        for (int k = 0; k < n_px; k++) begin
            fs = (k == 0 && !resume) || ($urandom_range(0, 59) == 0);
            send_pixel(pick_chan(), pick_chan(), pick_chan(), fs);
            if ($urandom_range(0, 299) == 0) drain();
        end
    endtask

    initial begin : stimulus
        int rr, cc, phase_no;
        sb = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: factor left at reset, two pixels per row, both channel extremes
        set_config(1'b0, F_HALF, 1'b1, 9'd2);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
        send_pixel(8'hFF, 8'h00, 8'hFE, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'hFD, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h01, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h02, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h03, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);

        // directed: thirds, width four so the last pixel of each row is a leftover
        // beyond the right edge; sums chosen so the divide by nine truncates
        drain();
        set_config(1'b1, F_THIRD, 1'b1, 9'd4);
        for (rr = 0; rr < 3; rr++)
            for (cc = 0; cc < 4; cc++)
                if (cc == 3)
                    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
                else
                    send_pixel((rr == 2 && cc == 2) ? 8'hFE : 8'hFF, CH_W'(rr * 3 + cc + 1),
                               (rr == 1 && cc == 1) ? 8'h08 : 8'h00, rr == 0 && cc == 0);

        // full width of halves, written as an oversized width: two rows fill every
        // line accumulator entry and reach the top output columns
        drain();
        set_config(1'b1, F_HALF, 1'b1, 9'h1FF);
        for (int k = 0; k < 2 * MAX_W; k++)
            send_pixel(pick_chan(), pick_chan(), pick_chan(), k == 0);

        // one-pixel rows give no means but advance the output row quickly; the width
        // then changes mid-frame so the row number is seen wrapping past 255
        drain();
        set_config(1'b1, 3'd1, 1'b1, 9'd1);
        for (int k = 0; k < 510; k++)
            send_pixel(pick_chan(), pick_chan(), pick_chan(), k == 0);
        drain();
        set_config(1'b0, F_HALF, 1'b1, 9'd2);
        for (int k = 0; k < 44; k++)
            send_pixel(pick_chan(), pick_chan(), pick_chan(), 1'b0);

        // random phases until the item count is reached
        phase_no = 0;
        while (pixels_sent < ITEM_TARGET) begin
            run_phase(phase_no);
            phase_no++;
        end

        drain();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // hard stop for a hung handshake
    initial begin : watchdog
        #(RUN_LIMIT * 2 * CLK_HALF);
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/bads_pkg.sv
rtl/box_average_downscaler_unit.sv
tb/tb.sv
